/* src/compliant_pid_joint_controller_macros.svh */
// Assertion macros shared by the joint controller RTL.
`ifndef COMPLIANT_PID_JOINT_CONTROLLER_MACROS_SVH
`define COMPLIANT_PID_JOINT_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active.
`define CPJC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define CPJC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPJC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CPJC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/cpjc_pkg.sv */
// Shared constants, codes and state types of the joint controller.
`default_nettype none
package cpjc_pkg;

  localparam int INTEGRAL_WIDTH = 32;

  localparam int GAIN_W     = 48;
  localparam int ERR_W      = 17;
  localparam int DER_W      = 18;
  localparam int ANGLE_W    = 16;
  localparam int TORQUE_W   = 47;
  localparam int SCALE_W    = 17;
  localparam int DUTY_W     = 14;
  localparam int QUO_W      = 14;
  localparam int REM_W      = 22;
  localparam int TIME_W     = 32;
  localparam int ID_W       = 11;
  localparam int TMO_W      = 16;
  localparam int COMP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;

  // Torque clamp of 6000 units in Q32.
  localparam logic [TORQUE_W-1:0] TORQUE_LIMIT = 47'd6000 << 32;
  // 5000 * 255 * 2^32 plus half of 255 * 2^32 for rounding.
  localparam logic [64:0] DUTY_OFFSET = 65'd2550255 << 31;
  // Any scaled value at or above 10001 * 255 saturates the duty.
  localparam logic [32:0] DUTY_SAT_Q = 33'd2550255;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 14'd10000;
  localparam logic [REM_W-1:0] DIV_START = 22'd255 << (QUO_W - 1);

  localparam logic [ID_W-1:0]   RST_CMD_ID  = 11'd513;
  localparam logic [TMO_W-1:0]  RST_TIMEOUT = 16'd100;
  localparam logic [COMP_W-1:0] RST_FS_COMP = 8'd230;
  localparam logic [GAIN_W-1:0] RST_KP      = 48'd429496730;
  localparam logic [GAIN_W-1:0] RST_KI      = 48'd4295;
  localparam logic [GAIN_W-1:0] RST_KD      = 48'd42949672960;

  localparam logic [CFG_IDX_W-1:0] REG_CMD_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FS_COMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd5;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_LOAD,
    ST_MAC,
    ST_DUTY,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_RUN,
    MAC_CLAMP
  } mac_state_t;

  typedef enum logic [1:0] {
    DU_IDLE,
    DU_MUL,
    DU_NORM,
    DU_DIV
  } duty_state_t;

endpackage
`default_nettype wire

/* src/cpjc_pid_mac.sv */
// Bit-serial PID multiply-accumulate of three Q32 gains with torque clamp.
`default_nettype none
module cpjc_pid_mac #(
  parameter int INT_W = cpjc_pkg::INTEGRAL_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [cpjc_pkg::GAIN_W-1:0]          kp,
  input  logic [cpjc_pkg::GAIN_W-1:0]          ki,
  input  logic [cpjc_pkg::GAIN_W-1:0]          kd,
  input  logic signed [cpjc_pkg::ERR_W-1:0]    err,
  input  logic signed [INT_W-1:0]              integ,
  input  logic signed [cpjc_pkg::DER_W-1:0]    deriv,
  output logic                                 done,
  output logic signed [cpjc_pkg::TORQUE_W-1:0] torque
);
  import cpjc_pkg::*;

  localparam int MUL_W = (INT_W > DER_W) ? INT_W : DER_W;
  localparam int ACC_W = GAIN_W + MUL_W + 3;
  localparam int CNT_W = $clog2(MUL_W);
  localparam logic signed [ACC_W-1:0] LIMIT_P = ACC_W'(TORQUE_LIMIT);
  localparam logic signed [ACC_W-1:0] LIMIT_N = -LIMIT_P;

  mac_state_t st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic done_r, done_nxt;
  logic [MUL_W-1:0] e_sr_r, i_sr_r, d_sr_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_shl, add_ext;
  logic signed [TORQUE_W-1:0] torque_r;
  logic [GAIN_W+1:0] addend;

  // Each cycle one bit of every multiplier enters, most significant first;
  // the sign bit carries negative weight.
  always_comb begin
    addend = (GAIN_W+2)'(e_sr_r[MUL_W-1] ? kp : '0)
           + (GAIN_W+2)'(i_sr_r[MUL_W-1] ? ki : '0)
           + (GAIN_W+2)'(d_sr_r[MUL_W-1] ? kd : '0);
    acc_shl = acc_r <<< 1;
    add_ext = signed'(ACC_W'(addend));
    acc_nxt = (cnt_r == '0) ? acc_shl - add_ext : acc_shl + add_ext;
  end

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    unique case (st_r)
      MAC_IDLE: begin
        if (start) st_nxt = MAC_RUN;
      end
      MAC_RUN: begin
        if (cnt_r == CNT_W'(MUL_W - 1)) st_nxt = MAC_CLAMP;
      end
      MAC_CLAMP: begin
        st_nxt   = MAC_IDLE;
        done_nxt = 1'b1;
      end
      default: st_nxt = MAC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MAC_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      if (st_r == MAC_RUN) cnt_r <= cnt_r + 1'b1;
      else cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      MAC_IDLE: begin
        if (start) begin
          e_sr_r <= MUL_W'(err);
          i_sr_r <= MUL_W'(integ);
          d_sr_r <= MUL_W'(deriv);
          acc_r  <= '0;
        end
      end
      MAC_RUN: begin
        e_sr_r <= e_sr_r << 1;
        i_sr_r <= i_sr_r << 1;
        d_sr_r <= d_sr_r << 1;
        acc_r  <= acc_nxt;
      end
      MAC_CLAMP: begin
        if (acc_r > LIMIT_P) torque_r <= LIMIT_P[TORQUE_W-1:0];
        else if (acc_r < LIMIT_N) torque_r <= LIMIT_N[TORQUE_W-1:0];
        else torque_r <= acc_r[TORQUE_W-1:0];
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign torque = torque_r;

endmodule
`default_nettype wire

/* src/cpjc_duty_scale.sv */
// Compliance scaling of the torque and bit-serial conversion to a PWM duty.
`default_nettype none
module cpjc_duty_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [cpjc_pkg::TORQUE_W-1:0] torque,
  input  logic [cpjc_pkg::COMP_W-1:0]          compliance,
  output logic                                 done,
  output logic [cpjc_pkg::DUTY_W-1:0]          duty
);
  import cpjc_pkg::*;

  localparam int PROD_W = TORQUE_W + SCALE_W;
  localparam int MCNT_W = $clog2(SCALE_W);
  localparam int DCNT_W = $clog2(QUO_W);

  duty_state_t st_r, st_nxt;
  logic [MCNT_W-1:0] mcnt_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic done_r, done_nxt;
  logic [SCALE_W-1:0] m_sr_r;
  logic signed [TORQUE_W-1:0] t_r;
  logic signed [PROD_W-1:0] p_r, p_add, p_nxt;
  logic [REM_W-1:0] rem_r, dv_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DUTY_W-1:0] duty_r;
  logic [COMP_W-1:0] slack;
  logic [SCALE_W-1:0] scale;
  logic signed [PROD_W:0] num;
  logic [32:0] num_q;
  logic rem_ge, num_neg, num_sat;

  // Scale factor 500 * (255 - compliance) built from shifts.
  always_comb begin
    slack = 8'd255 - compliance;
    scale = {slack, 9'b0} - (SCALE_W'(slack) << 3) - (SCALE_W'(slack) << 2);
  end

  always_comb begin
    p_add   = m_sr_r[SCALE_W-1] ? PROD_W'(t_r) : '0;
    p_nxt   = (p_r <<< 1) + p_add;
    num     = (PROD_W+1)'(p_r) + signed'(DUTY_OFFSET);
    num_q   = num[PROD_W:32];
    num_neg = num[PROD_W];
    num_sat = num_q >= DUTY_SAT_Q;
    rem_ge  = rem_r >= dv_r;
    quo_nxt = {quo_r[QUO_W-2:0], rem_ge};
  end

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    unique case (st_r)
      DU_IDLE: begin
        if (start) st_nxt = DU_MUL;
      end
      DU_MUL: begin
        if (mcnt_r == MCNT_W'(SCALE_W - 1)) st_nxt = DU_NORM;
      end
      DU_NORM: begin
        if (num_neg || num_sat) begin
          st_nxt   = DU_IDLE;
          done_nxt = 1'b1;
        end else begin
          st_nxt = DU_DIV;
        end
      end
      DU_DIV: begin
        if (dcnt_r == DCNT_W'(QUO_W - 1)) begin
          st_nxt   = DU_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = DU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DU_IDLE;
      done_r <= 1'b0;
      mcnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      if (st_r == DU_MUL) mcnt_r <= mcnt_r + 1'b1;
      else mcnt_r <= '0;
      if (st_r == DU_DIV) dcnt_r <= dcnt_r + 1'b1;
      else dcnt_r <= '0;
    end
  end

  // Division by 255 after the 2^32 shift: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    unique case (st_r)
      DU_IDLE: begin
        if (start) begin
          t_r    <= torque;
          m_sr_r <= scale;
          p_r    <= '0;
        end
      end
      DU_MUL: begin
        p_r    <= p_nxt;
        m_sr_r <= m_sr_r << 1;
      end
      DU_NORM: begin
        rem_r <= num_q[REM_W-1:0];
        dv_r  <= DIV_START;
        quo_r <= '0;
        if (num_neg) duty_r <= '0;
        else if (num_sat) duty_r <= DUTY_MAX;
      end
      DU_DIV: begin
        if (rem_ge) rem_r <= rem_r - dv_r;
        dv_r  <= dv_r >> 1;
        quo_r <= quo_nxt;
        if (dcnt_r == DCNT_W'(QUO_W - 1)) duty_r <= quo_nxt;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign duty = duty_r;

endmodule
`default_nettype wire

/* src/compliant_pid_joint_controller.sv */
// Top level of the compliant PID joint controller.
`default_nettype none
`include "compliant_pid_joint_controller_macros.svh"
// Usage:
// The in_ stream carries command frames (in_tuser low) and control ticks
// (in_tuser high). A frame whose identifier matches the configured id stores
// target angle, compliance and arrival time and gives no result. A tick
// checks the command timeout, runs one PID step and returns one duty value
// plus the timeout flag on the out_ stream. The gain products run one
// multiplier bit per cycle, then the compliance scaling runs as a bit-serial
// multiply and the division by 255 one quotient bit per cycle. A duty that
// is clamped to zero or full scale skips the division and comes out sooner.
// One item is in work at a time; in_tready is high only when idle, so a new
// tick is taken only after the last one's result is registered, and frames
// are taken once per cycle while idle.
// The result sits in an output register, so the next item is taken while it
// waits; if the receiver stalls, a finished tick waits for that register.
// The cfg_ port is always ready; it must be written only while the block is
// idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// target, compliance, command time, integral and previous error.
module compliant_pid_joint_controller #(
  parameter int INTEGRAL_WIDTH = cpjc_pkg::INTEGRAL_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // frame_id, angle_low_byte, angle_high_byte, compliance_byte, time_ms,
  // measured_angle, zero pad
  input  logic [cpjc_pkg::IN_DATA_W-1:0]      in_tdata,
  // action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // duty_hundredths, zero pad
  output logic [cpjc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // timed_out
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpjc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpjc_pkg::GAIN_W-1:0]         cfg_data
);
  import cpjc_pkg::*;

  localparam int IW = INTEGRAL_WIDTH;
  // The integral sum must hold any error even when the integral is narrow.
  localparam int SUM_W = ((IW > ERR_W) ? IW : ERR_W) + 1;

  ctl_state_t st_r, st_nxt;

  logic [ID_W-1:0]   cmd_id_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [COMP_W-1:0] fs_comp_r;
  logic [GAIN_W-1:0] kp_r, ki_r, kd_r;

  logic signed [ANGLE_W-1:0] target_r, meas_r, tgt_eff;
  logic [COMP_W-1:0] comp_r, eff_comp_r;
  logic [TIME_W-1:0] last_time_r, elapsed;
  logic signed [IW-1:0] integ_r, int_sat;
  logic signed [SUM_W-1:0] int_sum;
  logic signed [ERR_W-1:0] prev_err_r, err;
  logic signed [DER_W-1:0] deriv_r, der;
  logic timed_r, tick_timed;

  logic [ID_W-1:0]   in_frame_id;
  logic [7:0]        in_angle_lo, in_angle_hi;
  logic [COMP_W-1:0] in_comp;
  logic [TIME_W-1:0] in_time;
  logic signed [ANGLE_W-1:0] in_meas;

  logic in_acc, cfg_acc, out_load;
  logic mac_done, duty_done;
  logic signed [TORQUE_W-1:0] mac_torque;
  logic [DUTY_W-1:0] duty_val;

  logic out_valid_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic out_timed_r;

  assign in_frame_id = in_tdata[10:0];
  assign in_angle_lo = in_tdata[18:11];
  assign in_angle_hi = in_tdata[26:19];
  assign in_comp     = in_tdata[34:27];
  assign in_time     = in_tdata[66:35];
  assign in_meas     = signed'(in_tdata[82:67]);

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = (st_r == ST_OUT) && (!out_valid_r || out_tready);

  // Elapsed time wraps modulo 2^32.
  always_comb begin
    elapsed    = in_time - last_time_r;
    tick_timed = elapsed > TIME_W'(timeout_r);
  end

  always_comb begin
    tgt_eff = timed_r ? meas_r : target_r;
    err     = ERR_W'(tgt_eff) - ERR_W'(meas_r);
    int_sum = SUM_W'(integ_r) + SUM_W'(err);
    if (int_sum[SUM_W-1:IW-1] != {(SUM_W-IW+1){int_sum[SUM_W-1]}}) begin
      int_sat = int_sum[SUM_W-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      int_sat = int_sum[IW-1:0];
    end
    der = DER_W'(err) - DER_W'(prev_err_r);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == ACT_TICK)) st_nxt = ST_ERR;
      end
      ST_ERR:  st_nxt = ST_LOAD;
      ST_LOAD: st_nxt = ST_MAC;
      ST_MAC: begin
        if (mac_done) st_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        if (duty_done) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_id_r  <= RST_CMD_ID;
      timeout_r <= RST_TIMEOUT;
      fs_comp_r <= RST_FS_COMP;
      kp_r      <= RST_KP;
      ki_r      <= RST_KI;
      kd_r      <= RST_KD;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_CMD_ID:  cmd_id_r  <= cfg_data[ID_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data[TMO_W-1:0];
        REG_FS_COMP: fs_comp_r <= cfg_data[COMP_W-1:0];
        REG_KP:      kp_r      <= cfg_data;
        REG_KI:      ki_r      <= cfg_data;
        REG_KD:      kd_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      comp_r      <= '0;
      last_time_r <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
    end else begin
      if (in_acc && (in_tuser == ACT_FRAME) && (in_frame_id == cmd_id_r)) begin
        target_r    <= signed'({in_angle_hi, in_angle_lo});
        comp_r      <= in_comp;
        last_time_r <= in_time;
      end
      if (st_r == ST_ERR) begin
        if (timed_r) target_r <= meas_r;
        integ_r    <= int_sat;
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == ACT_TICK)) begin
      meas_r  <= in_meas;
      timed_r <= tick_timed;
    end
    if (st_r == ST_ERR) begin
      deriv_r    <= der;
      eff_comp_r <= timed_r ? fs_comp_r : comp_r;
    end
    if (out_load) begin
      out_duty_r  <= duty_val;
      out_timed_r <= timed_r;
    end
  end

  cpjc_pid_mac #(
    .INT_W(IW)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_LOAD),
    .kp    (kp_r),
    .ki    (ki_r),
    .kd    (kd_r),
    .err   (prev_err_r),
    .integ (integ_r),
    .deriv (deriv_r),
    .done  (mac_done),
    .torque(mac_torque)
  );

  cpjc_duty_scale u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mac_done),
    .torque    (mac_torque),
    .compliance(eff_comp_r),
    .done      (duty_done),
    .duty      (duty_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-DUTY_W){1'b0}}, out_duty_r};
  assign out_tuser  = out_timed_r;

  `CPJC_ASSERT_IMPL(a_mac_done_state, clk, rst_n, mac_done, st_r == ST_MAC, "mac done outside MAC state")
  `CPJC_ASSERT_IMPL(a_duty_done_state, clk, rst_n, duty_done, st_r == ST_DUTY, "duty done outside DUTY state")
  `CPJC_ASSERT_NEXT(a_tick_starts, clk, rst_n, in_acc && (in_tuser == ACT_TICK), st_r == ST_ERR, "tick transfer did not start a PID step")
  `CPJC_ASSERT_NEXT(a_frame_stays_idle, clk, rst_n, in_acc && (in_tuser == ACT_FRAME), st_r == ST_IDLE, "frame transfer left the idle state")
  `CPJC_ASSERT_IMPL(a_duty_range, clk, rst_n, out_valid_r, out_duty_r <= DUTY_MAX, "duty above full scale")

endmodule
`default_nettype wire
